>>> design/nfrs_pkg.sv
// Shared direction codes and divider constants for negative-first route selection.
package nfrs_pkg;

  typedef enum logic [2:0] {
    DIR_LEFT  = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_UP    = 3'd3,
    DIR_NONE  = 3'd4
  } dir_e;

  localparam int unsigned MASK_W     = 4;
  localparam int unsigned MASK_LEFT  = 0;
  localparam int unsigned MASK_DOWN  = 1;
  localparam int unsigned MASK_RIGHT = 2;
  localparam int unsigned MASK_UP    = 3;

  localparam int unsigned DIR_W      = 3;
  localparam int unsigned HASH_W     = 32;
  // Quotient of 0xFFFFFFFF by the distance sum, produced DIV_STEPS bits per stage
  localparam int unsigned QUO_W      = 32;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;

endpackage

>>> design/negative_first_route_select.sv
// Negative-first turn model route selection with a pipelined hash split.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------------------
//   in      | to block  | in_valid_i / in_stall_o   | cur_x_i cur_y_i dst_x_i dst_y_i
//           |           |                           | hash_value_i
//   out     | from block| out_valid_o / out_stall_i | legal_mask_o next_direction_o
//
// One item enters per cycle while in_stall_o is low. Each item passes a front register,
// then DIV_STAGES stages of the restoring divider that forms 0xFFFFFFFF / (dx + dy),
// DIV_STEPS quotient bits per stage, followed by one multiply stage and one compare stage.
// Reset clears only the valid bits; payload registers keep whatever they held.
// Each stage advances when its successor has room, so a stall at the output
// fills bubbles first and only then holds the input side.
module negative_first_route_select
  import nfrs_pkg::*;
#(
  parameter int unsigned COORD_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] cur_x_i,
  input  logic [COORD_BITS-1:0] cur_y_i,
  input  logic [COORD_BITS-1:0] dst_x_i,
  input  logic [COORD_BITS-1:0] dst_y_i,
  input  logic [HASH_W-1:0]     hash_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [MASK_W-1:0]     legal_mask_o,
  output logic [DIR_W-1:0]      next_direction_o
);

  localparam int unsigned SUM_W  = COORD_BITS + 1;
  // Front stage plus the divider stages share one set of arrays
  localparam int unsigned NST    = DIV_STAGES + 1;
  localparam int unsigned PROD_W = COORD_BITS + QUO_W;

  // ---------------------------------------------------------------------------
  // Front: legal mask, distances, single-move direction
  // ---------------------------------------------------------------------------
  logic                  lt_x, gt_x, lt_y, gt_y, neg_c, two_c;
  logic [COORD_BITS-1:0] dx_c, dy_c;
  logic [SUM_W-1:0]      sum_c;
  logic [MASK_W-1:0]     mask_c;
  dir_e                  dpre_c;

  always_comb begin
    lt_x  = dst_x_i < cur_x_i;
    gt_x  = dst_x_i > cur_x_i;
    lt_y  = dst_y_i < cur_y_i;
    gt_y  = dst_y_i > cur_y_i;
    neg_c = lt_x | lt_y;
    mask_c             = '0;
    mask_c[MASK_LEFT]  = lt_x;
    mask_c[MASK_DOWN]  = lt_y;
    mask_c[MASK_RIGHT] = ~neg_c & gt_x;
    mask_c[MASK_UP]    = ~neg_c & gt_y;
    // Two legal moves are always left+down or right+up
    two_c = neg_c ? (lt_x & lt_y) : (gt_x & gt_y);
    dx_c  = lt_x ? (cur_x_i - dst_x_i) : (dst_x_i - cur_x_i);
    dy_c  = lt_y ? (cur_y_i - dst_y_i) : (dst_y_i - cur_y_i);
    sum_c = {1'b0, dx_c} + {1'b0, dy_c};
    priority if (mask_c[MASK_LEFT])  dpre_c = DIR_LEFT;
    else if (mask_c[MASK_DOWN])      dpre_c = DIR_DOWN;
    else if (mask_c[MASK_RIGHT])     dpre_c = DIR_RIGHT;
    else if (mask_c[MASK_UP])        dpre_c = DIR_UP;
    else                             dpre_c = DIR_NONE;
  end

  // ---------------------------------------------------------------------------
  // Stage arrays: index 0 is the front register, 1..DIV_STAGES the divider
  // ---------------------------------------------------------------------------
  logic                  p_valid_q [NST];
  logic                  p_rdy     [NST];
  logic [MASK_W-1:0]     p_mask_q  [NST];
  dir_e                  p_dpre_q  [NST];
  logic                  p_two_q   [NST];
  logic                  p_neg_q   [NST];
  logic [COORD_BITS-1:0] p_dy_q    [NST];
  logic [SUM_W-1:0]      p_sum_q   [NST];
  logic [HASH_W-1:0]     p_hash_q  [NST];
  logic [SUM_W-1:0]      p_rem_q   [NST];
  logic [QUO_W-1:0]      p_quo_q   [NST];

  // Multiply and output stages
  logic              mul_valid_q, mul_rdy;
  logic [MASK_W-1:0] mul_mask_q;
  dir_e              mul_dpre_q;
  logic              mul_two_q, mul_neg_q;
  logic [HASH_W-1:0] mul_hash_q;
  logic [PROD_W-1:0] mul_prod_q;

  logic              out_valid_q, out_rdy;
  logic [MASK_W-1:0] out_mask_q;
  dir_e              out_dir_q;

  // Ready chain: a stage takes new data when empty or when it moves on itself
  assign out_rdy = ~out_valid_q | ~out_stall_i;
  assign mul_rdy = ~mul_valid_q | out_rdy;

  always_comb begin
    p_rdy[NST-1] = ~p_valid_q[NST-1] | mul_rdy;
    for (int k = NST - 2; k >= 0; k--) begin
      p_rdy[k] = ~p_valid_q[k] | p_rdy[k+1];
    end
  end

  assign in_stall_o = ~p_rdy[0];

  // Front register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q[0] <= 1'b0;
    end else if (p_rdy[0]) begin
      p_valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_rdy[0] && in_valid_i) begin
      p_mask_q[0] <= mask_c;
      p_dpre_q[0] <= dpre_c;
      p_two_q[0]  <= two_c;
      p_neg_q[0]  <= neg_c;
      p_dy_q[0]   <= dy_c;
      p_sum_q[0]  <= sum_c;
      p_hash_q[0] <= hash_value_i;
      p_rem_q[0]  <= '0;
      p_quo_q[0]  <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: the dividend is all ones, so shift in a one each step
  // ---------------------------------------------------------------------------
  for (genvar k = 1; k < NST; k++) begin : g_div
    logic [SUM_W-1:0] rem_c;
    logic [QUO_W-1:0] quo_c;
    logic [SUM_W:0]   trial;

    always_comb begin
      rem_c = p_rem_q[k-1];
      quo_c = p_quo_q[k-1];
      trial = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        trial = {rem_c, 1'b1};
        if (trial >= {1'b0, p_sum_q[k-1]}) begin
          trial = trial - {1'b0, p_sum_q[k-1]};
          quo_c = {quo_c[QUO_W-2:0], 1'b1};
        end else begin
          quo_c = {quo_c[QUO_W-2:0], 1'b0};
        end
        rem_c = trial[SUM_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        p_valid_q[k] <= 1'b0;
      end else if (p_rdy[k]) begin
        p_valid_q[k] <= p_valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (p_rdy[k] && p_valid_q[k-1]) begin
        p_mask_q[k] <= p_mask_q[k-1];
        p_dpre_q[k] <= p_dpre_q[k-1];
        p_two_q[k]  <= p_two_q[k-1];
        p_neg_q[k]  <= p_neg_q[k-1];
        p_dy_q[k]   <= p_dy_q[k-1];
        p_sum_q[k]  <= p_sum_q[k-1];
        p_hash_q[k] <= p_hash_q[k-1];
        p_rem_q[k]  <= rem_c;
        p_quo_q[k]  <= quo_c;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Split weight: dy * quotient
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_rdy) begin
      mul_valid_q <= p_valid_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_rdy && p_valid_q[NST-1]) begin
      mul_mask_q <= p_mask_q[NST-1];
      mul_dpre_q <= p_dpre_q[NST-1];
      mul_two_q  <= p_two_q[NST-1];
      mul_neg_q  <= p_neg_q[NST-1];
      mul_hash_q <= p_hash_q[NST-1];
      mul_prod_q <= {{QUO_W{1'b0}}, p_dy_q[NST-1]} * {{COORD_BITS{1'b0}}, p_quo_q[NST-1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Compare hash against the weight and pick the move
  // ---------------------------------------------------------------------------
  logic hit_c;
  dir_e dir_c;

  always_comb begin
    hit_c = {{COORD_BITS{1'b0}}, mul_hash_q} < mul_prod_q;
    if (mul_two_q) begin
      if (hit_c) dir_c = mul_neg_q ? DIR_DOWN : DIR_UP;
      else       dir_c = mul_neg_q ? DIR_LEFT : DIR_RIGHT;
    end else begin
      dir_c = mul_dpre_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && mul_valid_q) begin
      out_mask_q <= mul_mask_q;
      out_dir_q  <= dir_c;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign legal_mask_o     = out_mask_q;
  assign next_direction_o = out_dir_q;

endmodule

>>> design/nfrs_checker.sv
// Port-level checks for negative-first route selection, bound to the top level.
module nfrs_checker
  import nfrs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [MASK_W-1:0] legal_mask_o,
  input logic [DIR_W-1:0]  next_direction_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_direction_o)
      && $stable(legal_mask_o))
    else $error("stalled result changed or dropped");

  // Never mix negative and positive moves in one mask
  a_mask_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !((legal_mask_o[MASK_LEFT] || legal_mask_o[MASK_DOWN]) &&
                      (legal_mask_o[MASK_RIGHT] || legal_mask_o[MASK_UP])))
    else $error("negative and positive moves both legal");

  // Empty mask means arrived
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && legal_mask_o == '0 |-> next_direction_o == DIR_NONE)
    else $error("direction given at destination");

  // Chosen move is one of the legal ones
  a_dir_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && legal_mask_o != '0 |->
      (next_direction_o == DIR_LEFT  && legal_mask_o[MASK_LEFT])  ||
      (next_direction_o == DIR_DOWN  && legal_mask_o[MASK_DOWN])  ||
      (next_direction_o == DIR_RIGHT && legal_mask_o[MASK_RIGHT]) ||
      (next_direction_o == DIR_UP    && legal_mask_o[MASK_UP]))
    else $error("chosen move not in legal mask");

endmodule

bind negative_first_route_select nfrs_checker u_nfrs_checker (.*);
